>>> rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Types, codes and sizes shared by the pending tuple table.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int KEY_W       = 64;
    localparam int SLOT_W      = 4;
    localparam int CNT_W       = 5;
    localparam int FREED_MAX   = 31;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_FLUSH  = 2'd2,
        MODE_LOOKUP = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SPACE_ZERO  = 3'd1,
        ST_PTR_ZERO    = 3'd2,
        ST_THREAD_ZERO = 3'd3,
        ST_FULL        = 3'd4,
        ST_NOT_FOUND   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_FLUSH  = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_REJECT = 3'd4
    } op_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [KEY_W-1:0]  space_id;
        logic [KEY_W-1:0]  instr_ptr;
        logic [KEY_W-1:0]  thread_id;
        logic [SLOT_W-1:0] slot_in;
    } req_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_out;
        logic [CNT_W-1:0]  freed_count;
    } rsp_item_t;

    typedef struct packed {
        op_t               op;
        status_t           reject_status;
        logic [KEY_W-1:0]  space_id;
        logic [KEY_W-1:0]  instr_ptr;
        logic [KEY_W-1:0]  thread_id;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

endpackage

>>> rtl/ptt_front.sv
// ----------------------------------------------------------------------------
// ptt_front
// Accepts request items, decodes the mode and screens add keys for zeros.
// ----------------------------------------------------------------------------
module ptt_front (
    input  logic              req_valid,
    output logic              req_stall,
    input  ptt_pkg::req_item_t req_item,
    input  logic              q_full,
    output logic              q_push,
    output ptt_pkg::cmd_t     q_cmd
);
    import ptt_pkg::*;

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        q_cmd.op            = OP_REJECT;
        q_cmd.reject_status = ST_OK;
        q_cmd.space_id      = req_item.space_id;
        q_cmd.instr_ptr     = req_item.instr_ptr;
        q_cmd.thread_id     = req_item.thread_id;
        q_cmd.slot          = req_item.slot_in;
        case (mode_t'(req_item.mode))
            MODE_ADD:
            begin
                if (req_item.space_id == '0)
                begin
                    q_cmd.reject_status = ST_SPACE_ZERO;
                end
                else if (req_item.instr_ptr == '0)
                begin
                    q_cmd.reject_status = ST_PTR_ZERO;
                end
                else if (req_item.thread_id == '0)
                begin
                    q_cmd.reject_status = ST_THREAD_ZERO;
                end
                else
                begin
                    q_cmd.op = OP_ADD;
                end
            end
            MODE_REMOVE: q_cmd.op = OP_REMOVE;
            MODE_FLUSH:  q_cmd.op = OP_FLUSH;
            MODE_LOOKUP: q_cmd.op = OP_LOOKUP;
            default:     q_cmd.op = OP_REJECT;
        endcase
    end

endmodule

>>> rtl/ptt_queue.sv
// ----------------------------------------------------------------------------
// ptt_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module ptt_queue #(
    parameter int DEPTH = ptt_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ptt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output ptt_pkg::cmd_t head_cmd
);
    import ptt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_B = $clog2(DEPTH + 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_B-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_B'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/ptt_back.sv
// ----------------------------------------------------------------------------
// ptt_back
// Entry table: compares all entries at once into registered hit vectors, then
// resolves and updates once the result register can take the result, and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module ptt_back #(
    parameter int ENTRIES = ptt_pkg::ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  ptt_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ptt_pkg::rsp_item_t rsp_item
);
    import ptt_pkg::*;

    localparam int CNT_B = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE    = 2'b01,
        S_RESOLVE = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [KEY_W-1:0]     space_reg   [ENTRIES];
    logic [KEY_W-1:0]     pointer_reg [ENTRIES];
    logic [KEY_W-1:0]     thread_reg  [ENTRIES];
    cmd_t                 cmd_reg;
    logic [ENTRIES-1:0]   space_hit_reg;
    logic [ENTRIES-1:0]   key_hit_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_item_t            rsp_item_reg, rsp_item_next;

    logic                 can_emit;
    logic                 emit;
    logic [ENTRIES-1:0]   pick_vec;
    logic [ENTRIES-1:0]   pick_onehot;
    logic [SLOT_W-1:0]    pick_slot;
    logic [CNT_B-1:0]     hit_count;
    logic [CNT_W-1:0]     freed_sat;
    logic [ENTRIES-1:0]   wr_en;
    rsp_item_t            result;

    assign can_emit  = !rsp_valid_reg || !rsp_stall;
    assign emit      = (state_reg == S_RESOLVE) && can_emit;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // lowest set bit wins: free slots for add, key hits for lookup
    assign pick_vec    = (cmd_reg.op == OP_ADD) ? ~valid_reg : key_hit_reg;
    assign pick_onehot = pick_vec & (~pick_vec + ENTRIES'(1));

    always_comb
    begin
        pick_slot = '0;
        hit_count = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (pick_onehot[i])
            begin
                pick_slot = pick_slot | SLOT_W'(i);
            end
            hit_count = hit_count + CNT_B'(space_hit_reg[i]);
        end
        freed_sat = (32'(hit_count) > FREED_MAX) ? CNT_W'(FREED_MAX) : CNT_W'(hit_count);
    end

    always_comb
    begin
        valid_next         = valid_reg;
        wr_en              = '0;
        result.status      = ST_OK;
        result.slot_out    = '0;
        result.freed_count = '0;
        case (cmd_reg.op)
            OP_ADD:
            begin
                if (|pick_vec)
                begin
                    valid_next      = valid_reg | pick_onehot;
                    wr_en           = pick_onehot;
                    result.slot_out = pick_slot;
                end
                else
                begin
                    result.status = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (32'(cmd_reg.slot) == 32'(i))
                    begin
                        valid_next[i] = 1'b0;
                    end
                end
            end
            OP_FLUSH:
            begin
                valid_next         = valid_reg & ~space_hit_reg;
                result.freed_count = freed_sat;
            end
            OP_LOOKUP:
            begin
                if (|key_hit_reg)
                begin
                    result.slot_out = pick_slot;
                end
                else
                begin
                    result.status = ST_NOT_FOUND;
                end
            end
            OP_REJECT: result.status = cmd_reg.reject_status;
            default:   result.status = ST_OK;
        endcase
        if (!emit)
        begin
            valid_next = valid_reg;
            wr_en      = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (can_emit)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_item_next  = result;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
            for (int i = 0; i < ENTRIES; i++)
            begin
                space_hit_reg[i] <= valid_reg[i] && (space_reg[i] == q_cmd.space_id);
                key_hit_reg[i]   <= valid_reg[i] && (space_reg[i] == q_cmd.space_id)
                                    && (pointer_reg[i] == q_cmd.instr_ptr)
                                    && (thread_reg[i] == q_cmd.thread_id);
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (wr_en[i])
            begin
                space_reg[i]   <= cmd_reg.space_id;
                pointer_reg[i] <= cmd_reg.instr_ptr;
                thread_reg[i]  <= cmd_reg.thread_id;
            end
        end
    end

`ifndef SYNTHESIS
    a_add_fills_one: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cmd_reg.op == OP_ADD && !(&valid_reg))
        |=> $countones(valid_reg) == $past($countones(valid_reg)) + 1)
        else $error("add did not fill exactly one entry");

    a_flush_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cmd_reg.op == OP_FLUSH)
        |=> $countones(valid_reg) <= $past($countones(valid_reg)))
        else $error("flush filled an entry");

    a_result_after_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESOLVE))
        else $error("result shown without a resolve cycle");

    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESOLVE && !can_emit)
        |=> state_reg == S_RESOLVE && $stable(valid_reg))
        else $error("table changed while result blocked");
`endif

endmodule

>>> rtl/pending_tuple_table.sv
// ----------------------------------------------------------------------------
// pending_tuple_table
// Table of pending (space, pointer, thread) entries with add, remove, flush
// and lookup.
//
//   channel  | signals                     | direction
//   request  | req_valid req_stall req_item | in  (stall driven here)
//   response | rsp_valid rsp_stall rsp_item | out (stall driven by sink)
//
// One item at a time: the back end compares a popped item in its idle state,
// resolves it over the register table in its resolve state and pops no new
// item until the result register takes its result.
// A 2-deep queue lets the request side keep accepting, until it is full, while
// a result is stalled. Reset clears the valid marks, queue and control; no
// clearing pass. A stalled result holds the table and blocks further resolves.
// ----------------------------------------------------------------------------
module pending_tuple_table #(
    parameter int ENTRIES = ptt_pkg::ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  ptt_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ptt_pkg::rsp_item_t rsp_item
);
    import ptt_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head_cmd;

    ptt_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    ptt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    ptt_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_head_cmd),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule
